// ===== design/xcot_pkg.sv =====
// ----------------------------------------------------------------------------
// xcot_pkg: shared types and constants for the XOR cursor overlay tracker
// Transaction structs, event codes, register indexes and the arrow mask.
// ----------------------------------------------------------------------------
package xcot_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_CURSOR_ENABLE = 2'd2;

    // Item types
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Event kinds
    localparam logic [1:0] EV_SYNC  = 2'd0;
    localparam logic [1:0] EV_KEY   = 2'd1;
    localparam logic [1:0] EV_REL   = 2'd2;
    localparam logic [1:0] EV_OTHER = 2'd3;

    // Event codes
    localparam logic [1:0] KEY_LEFT   = 2'd0;
    localparam logic [1:0] KEY_RIGHT  = 2'd1;
    localparam logic [1:0] KEY_MIDDLE = 2'd2;
    localparam logic [1:0] REL_X      = 2'd0;
    localparam logic [1:0] REL_Y      = 2'd1;

    // Sizes and reset values
    localparam int unsigned CURSOR_COLS = 16;
    localparam int unsigned CURSOR_ROWS = 16;
    localparam logic [12:0] SIZE_MAX_PIX     = 13'd4096;
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd800;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd600;
    localparam logic [11:0] CUR_COL_RST      = 12'd400;
    localparam logic [11:0] CUR_ROW_RST      = 12'd300;
    localparam logic [23:0] ACC_MAX          = 24'h7F_FFFF;
    localparam logic [23:0] ACC_MIN          = 24'h80_0000;
    localparam logic [15:0] PIX_INVERT       = 16'hFFFF;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         ev_kind;
        logic [1:0]         ev_code;
        logic signed [15:0] ev_value;
        logic [11:0]        pix_x;
        logic [11:0]        pix_y;
        logic [15:0]        pix_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pix_out;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [2:0]  buttons;
    } t_out_item;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
    } t_cursor;

    typedef struct packed {
        t_cursor    pos;
        logic [2:0] buttons;
    } t_track;

    // Frame size as used for clamping: zero acts as one, capped at 4096
    function automatic logic [12:0] eff_size(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > SIZE_MAX_PIX) begin
            r = SIZE_MAX_PIX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // 16x16 arrow, MSB is the leftmost column
    function automatic logic [15:0] arrow_row(input logic [3:0] r);
        logic [15:0] m;
        case (r)
            4'd0:    m = 16'h8000;
            4'd1:    m = 16'hC000;
            4'd2:    m = 16'hE000;
            4'd3:    m = 16'hF000;
            4'd4:    m = 16'hF800;
            4'd5:    m = 16'hFC00;
            4'd6:    m = 16'hFE00;
            4'd7:    m = 16'hFF00;
            4'd8:    m = 16'hF800;
            4'd9:    m = 16'hCC00;
            4'd10:   m = 16'h8600;
            4'd11:   m = 16'h0600;
            4'd12:   m = 16'h0300;
            4'd13:   m = 16'h0300;
            4'd14:   m = 16'h0180;
            4'd15:   m = 16'h0180;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

// ===== design/xcot_state.sv =====
// ----------------------------------------------------------------------------
// xcot_state: cursor, accumulator and button state
// Applies one event per step: button updates, saturating motion accumulation
// and the clamped cursor move on sync.
// ----------------------------------------------------------------------------
module xcot_state
    import xcot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    input  logic [12:0] i_width_eff,
    input  logic [12:0] i_height_eff,
    output t_cursor     o_cur,
    output t_track      o_next
);

    logic [11:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [23:0] r_acc_dx, n_acc_dx;
    logic [23:0] r_acc_dy, n_acc_dy;
    logic [2:0]  r_buttons, n_buttons;

    logic        w_is_event;
    logic        w_move;
    logic [23:0] w_acc_sel;
    logic [24:0] w_acc_sum;
    logic [23:0] w_acc_sat;
    logic [25:0] w_col_sum;
    logic [25:0] w_row_sum;
    logic [11:0] w_col_clamp;
    logic [11:0] w_row_clamp;

    assign w_is_event = i_step && (i_item.cmd == CMD_EVENT);
    assign w_move     = w_is_event && (i_item.ev_kind == EV_SYNC)
                        && ((r_acc_dx != 24'd0) || (r_acc_dy != 24'd0));

    // Saturating add of the motion amount into the selected accumulator
    assign w_acc_sel = (i_item.ev_code == REL_Y) ? r_acc_dy : r_acc_dx;
    assign w_acc_sum = {w_acc_sel[23], w_acc_sel}
                       + {{9{i_item.ev_value[15]}}, i_item.ev_value};
    always_comb begin
        if (!w_acc_sum[24] && w_acc_sum[23]) begin
            w_acc_sat = ACC_MAX;
        end else if (w_acc_sum[24] && !w_acc_sum[23]) begin
            w_acc_sat = ACC_MIN;
        end else begin
            w_acc_sat = w_acc_sum[23:0];
        end
    end

    // Cursor move, clamped to the effective frame
    assign w_col_sum = {14'd0, r_col} + {{2{r_acc_dx[23]}}, r_acc_dx};
    assign w_row_sum = {14'd0, r_row} + {{2{r_acc_dy[23]}}, r_acc_dy};

    always_comb begin
        if (w_col_sum[25]) begin
            w_col_clamp = 12'd0;
        end else if (w_col_sum[24:0] >= {12'd0, i_width_eff}) begin
            w_col_clamp = 12'(i_width_eff - 13'd1);
        end else begin
            w_col_clamp = w_col_sum[11:0];
        end
        if (w_row_sum[25]) begin
            w_row_clamp = 12'd0;
        end else if (w_row_sum[24:0] >= {12'd0, i_height_eff}) begin
            w_row_clamp = 12'(i_height_eff - 13'd1);
        end else begin
            w_row_clamp = w_row_sum[11:0];
        end
    end

    // Next-state selection
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_acc_dx  = r_acc_dx;
        n_acc_dy  = r_acc_dy;
        n_buttons = r_buttons;
        if (w_is_event) begin
            case (i_item.ev_kind)
                EV_KEY: begin
                    if (i_item.ev_code <= KEY_MIDDLE) begin
                        n_buttons[i_item.ev_code] = (i_item.ev_value != 16'sd0);
                    end
                end
                EV_REL: begin
                    if (i_item.ev_code == REL_X) begin
                        n_acc_dx = w_acc_sat;
                    end else if (i_item.ev_code == REL_Y) begin
                        n_acc_dy = w_acc_sat;
                    end
                end
                EV_SYNC: begin
                    if (w_move) begin
                        n_col    = w_col_clamp;
                        n_row    = w_row_clamp;
                        n_acc_dx = 24'd0;
                        n_acc_dy = 24'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= CUR_COL_RST;
            r_row     <= CUR_ROW_RST;
            r_acc_dx  <= 24'd0;
            r_acc_dy  <= 24'd0;
            r_buttons <= 3'd0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_acc_dx  <= n_acc_dx;
            r_acc_dy  <= n_acc_dy;
            r_buttons <= n_buttons;
        end
    end

    assign o_cur.col      = r_col;
    assign o_cur.row      = r_row;
    assign o_next.pos.col = n_col;
    assign o_next.pos.row = n_row;
    assign o_next.buttons = n_buttons;

    // A move always empties both accumulators
    a_move_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_acc_dx == 24'd0) && (r_acc_dy == 24'd0))
        else $error("accumulators not cleared after move");

    // A move lands inside the frame
    a_move_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> ({1'b0, r_col} < i_width_eff) && ({1'b0, r_row} < i_height_eff))
        else $error("cursor outside frame after move");

    // Pixels leave the tracked state alone
    a_pixel_no_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.cmd == CMD_PIXEL)) |=>
            $stable(r_col) && $stable(r_row) && $stable(r_buttons)
            && $stable(r_acc_dx) && $stable(r_acc_dy))
        else $error("pixel transaction changed state");

endmodule

// ===== design/xcot_overlay.sv =====
// ----------------------------------------------------------------------------
// xcot_overlay: arrow mask hit test and pixel inversion
// Inverts a pixel inside the frame where the arrow at the cursor covers it, when enabled.
// ----------------------------------------------------------------------------
module xcot_overlay
    import xcot_pkg::*;
(
    input  t_in_item    i_item,
    input  t_cursor     i_cur,
    input  logic        i_enable,
    input  logic [12:0] i_width_eff,
    input  logic [12:0] i_height_eff,
    output logic [15:0] o_pix
);

    logic        w_in_frame;
    logic [12:0] w_dc;
    logic [12:0] w_dr;
    logic        w_in_box;
    logic [15:0] w_row_mask;
    logic        w_hit;

    assign w_in_frame = ({1'b0, i_item.pix_x} < i_width_eff)
                        && ({1'b0, i_item.pix_y} < i_height_eff);

    // Offset from the cursor anchor; the box is 0..15 in both directions
    assign w_dc     = {1'b0, i_item.pix_x} - {1'b0, i_cur.col};
    assign w_dr     = {1'b0, i_item.pix_y} - {1'b0, i_cur.row};
    assign w_in_box = (w_dc[12:4] == 9'd0) && (w_dr[12:4] == 9'd0);

    assign w_row_mask = arrow_row(w_dr[3:0]);
    assign w_hit = (i_item.cmd == CMD_PIXEL) && i_enable && w_in_frame && w_in_box
                   && w_row_mask[4'd15 - w_dc[3:0]];

    assign o_pix = w_hit ? (i_item.pix_in ^ PIX_INVERT) : i_item.pix_in;

endmodule

// ===== design/xor_cursor_overlay_tracker.sv =====
// ----------------------------------------------------------------------------
// xor_cursor_overlay_tracker: input event tracker with XOR cursor overlay
// Stages: input register and result register; state updates between them.
// Throughput: one transaction per cycle unless the result side stalls.
// Reset (synchronous, active low): cursor 400,300, accumulators and buttons
// cleared, frame 800x600, cursor shown, pipeline emptied.
// ----------------------------------------------------------------------------
module xor_cursor_overlay_tracker
    import xcot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic        r_cursor_enable;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        w_advance;
    logic        w_step;
    logic [12:0] w_width_eff;
    logic [12:0] w_height_eff;
    t_cursor     w_cur;
    t_track      w_next;
    logic [15:0] w_pix;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= FRAME_WIDTH_RST;
            r_frame_height  <= FRAME_HEIGHT_RST;
            r_cursor_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                CFG_CURSOR_ENABLE: r_cursor_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_width_eff  = eff_size(r_frame_width);
    assign w_height_eff = eff_size(r_frame_height);

    // Pipeline flow control
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
    end

    xcot_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_item       (r_in_item),
        .i_width_eff  (w_width_eff),
        .i_height_eff (w_height_eff),
        .o_cur        (w_cur),
        .o_next       (w_next)
    );

    xcot_overlay u_overlay (
        .i_item       (r_in_item),
        .i_cur        (w_cur),
        .i_enable     (r_cursor_enable),
        .i_width_eff  (w_width_eff),
        .i_height_eff (w_height_eff),
        .o_pix        (w_pix)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item.pix_out <= w_pix;
            r_out_item.pos_x   <= w_next.pos.col;
            r_out_item.pos_y   <= w_next.pos.row;
            r_out_item.buttons <= w_next.buttons;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    // Input side only stalls while holding a transaction
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // A processed transaction always reaches the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("transaction lost between stages");

endmodule
